### rtl/rlee_pkg.sv
// shared types and constants of the run-length escape encoder
`timescale 1ns / 1ps

package rlee_pkg;

    // ascii codes used in the token stream
    localparam logic [7:0] ESC_MARK   = 8'h40;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    // register indexes on the configuration port
    localparam logic REG_MIN_RUN = 1'b0;
    localparam logic REG_MAX_RUN = 1'b1;

    // register reset values
    localparam logic [3:0] MIN_RUN_RESET = 4'd4;
    localparam logic [3:0] MAX_RUN_RESET = 4'd9;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // one input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } text_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_burst;
    } code_item_t;

    // one run to flush, already classified
    typedef struct packed {
        logic       esc;
        logic [7:0] run_byte;
        logic [3:0] run_count;
    } cmd_t;

endpackage

### rtl/rlee_front.sv
// front end: run tracking and flush classification
`timescale 1ns / 1ps

module rlee_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlee_pkg::text_item_t text_item,
    input  logic [3:0]          min_run,
    input  logic [3:0]          max_run,
    input  logic                q_full,
    output logic                q_push,
    output rlee_pkg::cmd_t      q_cmd
);

    localparam logic [3:0] RUN_LOW       = 4'd2;
    localparam logic [3:0] RUN_HIGH      = 4'd9;
    localparam logic [3:0] LITERAL_LIMIT = 4'd3;

    logic [7:0] run_byte_reg;
    logic [7:0] run_byte_next;
    logic [3:0] run_count_reg;
    logic [3:0] run_count_next;
    logic       accept;
    logic       flush;
    logic [3:0] min_eff;
    logic [3:0] max_eff;

    function automatic logic [3:0] clamp_run(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < RUN_LOW)
        begin
            r = RUN_LOW;
        end
        else if (v > RUN_HIGH)
        begin
            r = RUN_HIGH;
        end
        return r;
    endfunction

    assign accept  = push && !q_full;
    assign min_eff = clamp_run(min_run);
    assign max_eff = clamp_run(max_run);

    // next run state and flush decision
    always_comb
    begin
        run_byte_next  = run_byte_reg;
        run_count_next = run_count_reg;
        flush          = 1'b0;
        if (accept)
        begin
            if (text_item.end_of_text)
            begin
                flush          = (run_count_reg != 4'd0);
                run_byte_next  = 8'd0;
                run_count_next = 4'd0;
            end
            else if (run_count_reg != 4'd0 && text_item.in_char == run_byte_reg
                     && run_count_reg < max_eff)
            begin
                run_count_next = run_count_reg + 4'd1;
            end
            else
            begin
                flush          = (run_count_reg != 4'd0);
                run_byte_next  = text_item.in_char;
                run_count_next = 4'd1;
            end
        end
    end

    // flushed run goes to the queue with its form decided
    always_comb
    begin
        q_push          = flush;
        q_cmd.esc       = (run_count_reg >= min_eff) || (run_count_reg > LITERAL_LIMIT);
        q_cmd.run_byte  = run_byte_reg;
        q_cmd.run_count = run_count_reg;
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_byte_reg  <= 8'd0;
            run_count_reg <= 4'd0;
        end
        else
        begin
            run_byte_reg  <= run_byte_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

### rtl/rlee_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module rlee_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  rlee_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd,
    output rlee_pkg::cmd_t rd_cmd,
    output logic           not_empty
);

    rlee_pkg::cmd_t                    mem_reg [rlee_pkg::CMD_DEPTH];
    logic [rlee_pkg::CMD_PTR_W-1:0]    wr_ptr_reg;
    logic [rlee_pkg::CMD_PTR_W-1:0]    rd_ptr_reg;
    logic [rlee_pkg::CMD_CNT_W-1:0]    count_reg;
    logic [rlee_pkg::CMD_CNT_W-1:0]    count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full      = (count_reg == rlee_pkg::CMD_CNT_W'(rlee_pkg::CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;
    assign rd_cmd    = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### rtl/rlee_back.sv
// back end: expands flush commands into output bytes
`timescale 1ns / 1ps

module rlee_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  rlee_pkg::cmd_t        q_cmd,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output rlee_pkg::code_item_t  code_item
);

    localparam logic [1:0] STEP_MARK  = 2'd0;
    localparam logic [1:0] STEP_BYTE  = 2'd1;
    localparam logic [1:0] STEP_DIGIT = 2'd2;

    rlee_pkg::cmd_t       cur_reg;
    logic                 cur_valid_reg;
    logic [1:0]           step_reg;
    rlee_pkg::code_item_t out_reg;
    logic                 out_valid_reg;
    logic                 load_out;
    logic                 last;
    logic [7:0]           sel_byte;

    // byte for the current step and end of command
    always_comb
    begin
        if (cur_reg.esc)
        begin
            last = (step_reg == STEP_DIGIT);
            case (step_reg)
                STEP_MARK:  sel_byte = rlee_pkg::ESC_MARK;
                STEP_BYTE:  sel_byte = cur_reg.run_byte;
                STEP_DIGIT: sel_byte = rlee_pkg::DIGIT_ZERO + {4'd0, cur_reg.run_count};
                default:    sel_byte = cur_reg.run_byte;
            endcase
        end
        else
        begin
            last     = ({2'd0, step_reg} == cur_reg.run_count - 4'd1);
            sel_byte = cur_reg.run_byte;
        end
    end

    assign load_out = cur_valid_reg && (!out_valid_reg || pop);
    assign q_pop    = q_valid && (!cur_valid_reg || (load_out && last));
    assign empty    = !out_valid_reg;
    assign code_item = out_reg;

    // command in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_MARK;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= STEP_MARK;
            end
            else if (load_out)
            begin
                cur_valid_reg <= !last;
                step_reg      <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.out_byte      <= sel_byte;
            out_reg.last_of_burst <= last;
        end
    end

endmodule

### rtl/run_length_escape_encoder_top.sv
// top level of the run-length escape encoder
//
// Input channel: text_item is taken on a clock edge with push high and full
// low. Result channel: while empty is low, code_item holds the oldest byte;
// it is taken on an edge with pop high. Registers min_run (address 0) and
// max_run (address 4) are written and read over the APB port; the user must
// do so only while idle; the block does not check it. A flushed run goes via
// the queue and command register to the output register. Throughput: one
// input item per cycle while full is low; the back end emits one byte per
// cycle while pop is high, set by the single output register. A four-entry
// command queue between the run tracker and the byte expander absorbs
// bursts of escape tokens; full rises when the receiver stalls long enough
// to fill it, or when short runs sent as escape tokens (min_run of 2) arrive
// faster than the back end can spell them out, three bytes for every two
// inputs. Reset clears the pending run, the queue and the output, and sets
// min_run to 4 and max_run to 9. A stalled receiver holds code_item stable.
`timescale 1ns / 1ps

module run_length_escape_encoder_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rlee_pkg::text_item_t text_item,
    output logic                 empty,
    input  logic                 pop,
    output rlee_pkg::code_item_t code_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [3:0]     min_run_reg;
    logic [3:0]     max_run_reg;
    logic           cfg_wr;
    logic           q_full;
    logic           q_push;
    rlee_pkg::cmd_t q_wr_cmd;
    logic           q_pop;
    rlee_pkg::cmd_t q_rd_cmd;
    logic           q_valid;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg <= rlee_pkg::MIN_RUN_RESET;
            max_run_reg <= rlee_pkg::MAX_RUN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                rlee_pkg::REG_MIN_RUN: min_run_reg <= pwdata[3:0];
                rlee_pkg::REG_MAX_RUN: max_run_reg <= pwdata[3:0];
                default:               min_run_reg <= min_run_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[2])
            rlee_pkg::REG_MIN_RUN: prdata = {28'd0, min_run_reg};
            rlee_pkg::REG_MAX_RUN: prdata = {28'd0, max_run_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign full = q_full;

    // run tracking
    rlee_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_item (text_item),
        .min_run   (min_run_reg),
        .max_run   (max_run_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    // command queue
    rlee_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_push),
        .wr_cmd    (q_wr_cmd),
        .full      (q_full),
        .rd        (q_pop),
        .rd_cmd    (q_rd_cmd),
        .not_empty (q_valid)
    );

    // byte expansion
    rlee_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_rd_cmd),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .code_item (code_item)
    );

endmodule
